// File: sv/gtl_pkg.sv
// Shared types, constants and the character mapping table of the Greek to Latin transliterator.
package gtl_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] GREEK_FIRST = 8'd182;
    localparam logic [7:0] CAP_MU      = 8'd204;
    localparam logic [7:0] CAP_NU      = 8'd205;
    localparam logic [7:0] SMALL_MU    = 8'd236;
    localparam logic [7:0] SMALL_NU    = 8'd237;
    localparam logic [7:0] CAP_PI      = 8'd208;
    localparam logic [7:0] SMALL_PI    = 8'd240;
    localparam logic [7:0] CAP_TAU     = 8'd212;
    localparam logic [7:0] SMALL_TAU   = 8'd244;
    localparam logic [7:0] CHAR_NL     = 8'h0A;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][7:0] chars;
    } gtl_map_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } gtl_run_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } gtl_queue_status_t;

    function automatic gtl_map_t gtl_mk(input logic [1:0] len, input logic [7:0] c0,
                                        input logic [7:0] c1, input logic [7:0] c2);
        gtl_map_t m;
        m.len      = len;
        m.chars[0] = c0;
        m.chars[1] = c1;
        m.chars[2] = c2;
        return m;
    endfunction

    function automatic logic gtl_is_hold(input logic [7:0] b);
        return (b == CAP_MU) || (b == SMALL_MU) || (b == CAP_NU) || (b == SMALL_NU);
    endfunction

    function automatic gtl_map_t gtl_map(input logic [7:0] b);
        gtl_map_t m;
        m = gtl_mk(2'd0, 8'h00, 8'h00, 8'h00);
        if (b < GREEK_FIRST) begin
            m = gtl_mk(2'd1, b, 8'h00, 8'h00);
        end
        else begin
            unique case (b)
                8'd182: m = gtl_mk(2'd2, "'", "A", 8'h00);
                8'd183: m = gtl_mk(2'd1, 8'hB7, 8'h00, 8'h00);
                8'd184: m = gtl_mk(2'd2, "'", "E", 8'h00);
                8'd185: m = gtl_mk(2'd2, "'", "H", 8'h00);
                8'd186: m = gtl_mk(2'd2, "'", "I", 8'h00);
                8'd187: m = gtl_mk(2'd1, 8'hBB, 8'h00, 8'h00);
                8'd188: m = gtl_mk(2'd2, "'", "O", 8'h00);
                8'd189: m = gtl_mk(2'd1, 8'hBD, 8'h00, 8'h00);
                8'd190: m = gtl_mk(2'd2, "'", "Y", 8'h00);
                8'd191: m = gtl_mk(2'd2, "'", "W", 8'h00);
                8'd192: m = gtl_mk(2'd3, "i", "'", "\"");
                8'd193: m = gtl_mk(2'd1, "A", 8'h00, 8'h00);
                8'd194: m = gtl_mk(2'd1, "V", 8'h00, 8'h00);
                8'd195: m = gtl_mk(2'd1, "G", 8'h00, 8'h00);
                8'd196: m = gtl_mk(2'd1, "D", 8'h00, 8'h00);
                8'd197: m = gtl_mk(2'd1, "E", 8'h00, 8'h00);
                8'd198: m = gtl_mk(2'd1, "Z", 8'h00, 8'h00);
                8'd199: m = gtl_mk(2'd1, "H", 8'h00, 8'h00);
                8'd200: m = gtl_mk(2'd1, "8", 8'h00, 8'h00);
                8'd201: m = gtl_mk(2'd1, "I", 8'h00, 8'h00);
                8'd202: m = gtl_mk(2'd1, "K", 8'h00, 8'h00);
                8'd203: m = gtl_mk(2'd1, "L", 8'h00, 8'h00);
                8'd204: m = gtl_mk(2'd1, "M", 8'h00, 8'h00);
                8'd205: m = gtl_mk(2'd1, "N", 8'h00, 8'h00);
                8'd206: m = gtl_mk(2'd2, "K", "S", 8'h00);
                8'd207: m = gtl_mk(2'd1, "O", 8'h00, 8'h00);
                8'd208: m = gtl_mk(2'd1, "P", 8'h00, 8'h00);
                8'd209: m = gtl_mk(2'd1, "R", 8'h00, 8'h00);
                8'd211: m = gtl_mk(2'd1, "S", 8'h00, 8'h00);
                8'd212: m = gtl_mk(2'd1, "T", 8'h00, 8'h00);
                8'd213: m = gtl_mk(2'd1, "Y", 8'h00, 8'h00);
                8'd214: m = gtl_mk(2'd1, "F", 8'h00, 8'h00);
                8'd215: m = gtl_mk(2'd1, "X", 8'h00, 8'h00);
                8'd216: m = gtl_mk(2'd2, "P", "S", 8'h00);
                8'd217: m = gtl_mk(2'd1, "W", 8'h00, 8'h00);
                8'd218: m = gtl_mk(2'd2, "I", "\"", 8'h00);
                8'd219: m = gtl_mk(2'd2, "Y", "\"", 8'h00);
                8'd220: m = gtl_mk(2'd2, "a", "'", 8'h00);
                8'd221: m = gtl_mk(2'd2, "e", "'", 8'h00);
                8'd222: m = gtl_mk(2'd2, "h", "'", 8'h00);
                8'd223: m = gtl_mk(2'd2, "i", "'", 8'h00);
                8'd224: m = gtl_mk(2'd3, "y", "'", "\"");
                8'd225: m = gtl_mk(2'd1, "a", 8'h00, 8'h00);
                8'd226: m = gtl_mk(2'd1, "v", 8'h00, 8'h00);
                8'd227: m = gtl_mk(2'd1, "g", 8'h00, 8'h00);
                8'd228: m = gtl_mk(2'd1, "d", 8'h00, 8'h00);
                8'd229: m = gtl_mk(2'd1, "e", 8'h00, 8'h00);
                8'd230: m = gtl_mk(2'd1, "z", 8'h00, 8'h00);
                8'd231: m = gtl_mk(2'd1, "h", 8'h00, 8'h00);
                8'd232: m = gtl_mk(2'd1, "8", 8'h00, 8'h00);
                8'd233: m = gtl_mk(2'd1, "i", 8'h00, 8'h00);
                8'd234: m = gtl_mk(2'd1, "k", 8'h00, 8'h00);
                8'd235: m = gtl_mk(2'd1, "l", 8'h00, 8'h00);
                8'd236: m = gtl_mk(2'd1, "m", 8'h00, 8'h00);
                8'd237: m = gtl_mk(2'd1, "n", 8'h00, 8'h00);
                8'd238: m = gtl_mk(2'd2, "k", "s", 8'h00);
                8'd239: m = gtl_mk(2'd1, "o", 8'h00, 8'h00);
                8'd240: m = gtl_mk(2'd1, "p", 8'h00, 8'h00);
                8'd241: m = gtl_mk(2'd1, "r", 8'h00, 8'h00);
                8'd242: m = gtl_mk(2'd1, "s", 8'h00, 8'h00);
                8'd243: m = gtl_mk(2'd1, "s", 8'h00, 8'h00);
                8'd244: m = gtl_mk(2'd1, "t", 8'h00, 8'h00);
                8'd245: m = gtl_mk(2'd1, "y", 8'h00, 8'h00);
                8'd246: m = gtl_mk(2'd1, "f", 8'h00, 8'h00);
                8'd247: m = gtl_mk(2'd1, "x", 8'h00, 8'h00);
                8'd248: m = gtl_mk(2'd2, "p", "s", 8'h00);
                8'd249: m = gtl_mk(2'd1, "w", 8'h00, 8'h00);
                8'd250: m = gtl_mk(2'd2, "i", "\"", 8'h00);
                8'd251: m = gtl_mk(2'd2, "y", "\"", 8'h00);
                8'd252: m = gtl_mk(2'd2, "o", "'", 8'h00);
                8'd253: m = gtl_mk(2'd2, "y", "'", 8'h00);
                8'd254: m = gtl_mk(2'd2, "w", "'", 8'h00);
                default: m = gtl_mk(2'd0, 8'h00, 8'h00, 8'h00);
            endcase
        end
        return m;
    endfunction

endpackage

// File: sv/gtl_front.sv
// Front end: accepts input transfers, tracks the held letter and builds the output run.
module gtl_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic [7:0]                 in_byte,
    input  gtl_pkg::gtl_queue_status_t q_status,
    output logic                       push,
    output gtl_pkg::gtl_run_t          push_run
);
    import gtl_pkg::*;

    logic            held_valid_reg;
    logic            held_valid_next;
    logic [7:0]      held_letter_reg;
    logic [7:0]      held_letter_next;
    gtl_map_t        held_map;
    gtl_map_t        in_map;
    logic            pre_en;
    logic [7:0]      pre_ch;
    logic [1:0]      tail_len;
    logic [2:0][7:0] tail_ch;
    logic            take;
    logic [2:0]      total;
    logic            accept;

    assign held_map = gtl_map(held_letter_reg);
    assign in_map   = gtl_map(in_byte);
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        pre_en           = 1'b0;
        pre_ch           = held_map.chars[0];
        tail_len         = 2'd0;
        tail_ch          = in_map.chars;
        take             = 1'b0;
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        if (command == CMD_END) begin
            pre_en          = held_valid_reg;
            tail_len        = 2'd1;
            tail_ch[0]      = CHAR_NL;
            held_valid_next = 1'b0;
        end
        else begin
            take = 1'b1;
            if (held_valid_reg) begin
                held_valid_next = 1'b0;
                pre_en          = 1'b1;
                if (((held_letter_reg == CAP_MU) || (held_letter_reg == SMALL_MU)) &&
                    ((in_byte == CAP_PI) || (in_byte == SMALL_PI))) begin
                    pre_ch = (held_letter_reg == CAP_MU) ? "B" : "b";
                    take   = 1'b0;
                end
                else if (((held_letter_reg == CAP_NU) || (held_letter_reg == SMALL_NU)) &&
                         ((in_byte == CAP_TAU) || (in_byte == SMALL_TAU))) begin
                    pre_ch = (held_letter_reg == CAP_NU) ? "D" : "d";
                    take   = 1'b0;
                end
            end
            if (take) begin
                if (gtl_is_hold(in_byte)) begin
                    held_valid_next  = 1'b1;
                    held_letter_next = in_byte;
                end
                else begin
                    tail_len = in_map.len;
                end
            end
        end
    end

    always_comb
    begin
        if (pre_en) begin
            push_run.bytes[0]   = pre_ch;
            push_run.bytes[3:1] = tail_ch;
        end
        else begin
            push_run.bytes[2:0] = tail_ch;
            push_run.bytes[3]   = 8'h00;
        end
        total             = {1'b0, tail_len} + {2'b00, pre_en};
        push_run.last_idx = 2'(total - 3'd1);
    end

    assign push = accept && (total != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg  <= 1'b0;
            held_letter_reg <= 8'd0;
        end
        else if (accept) begin
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
        end
    end

endmodule

// File: sv/gtl_queue.sv
// Short run queue between the front end and the back end.
module gtl_queue #(
    parameter int DEPTH = gtl_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  gtl_pkg::gtl_run_t          push_run,
    input  logic                       pop,
    output gtl_pkg::gtl_run_t          head_run,
    output gtl_pkg::gtl_queue_status_t status
);
    import gtl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    gtl_run_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full      = (count_reg == CNT_W'(DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign head_run         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

// File: sv/gtl_back.sv
// Back end: walks the head run one byte per cycle into the output register while the output is not stalled.
module gtl_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gtl_pkg::gtl_run_t          head_run,
    input  gtl_pkg::gtl_queue_status_t q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_byte,
    output logic                       last_of_run
);
    import gtl_pkg::*;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       load;
    logic       at_end;

    assign load   = !out_valid_reg || !out_stall;
    assign at_end = (idx_reg == head_run.last_idx);
    assign pop    = load && q_status.not_empty && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (load && q_status.not_empty) begin
            idx_next = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else begin
            idx_reg <= idx_next;
            if (load) begin
                out_valid_reg <= q_status.not_empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_byte_reg <= head_run.bytes[idx_reg];
            last_reg     <= at_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

// File: sv/greek_to_latin_transliterator.sv
// Top level of the ISO 8859-7 Greek to Latin transliterator.
// An input transfer's result bytes pass through a run queue entry and then the output register.
// Input transfers are taken one per cycle while the run queue has room.
// Results leave at one byte per cycle while out_stall is low and the run queue is not empty.
// The queue holds QUEUE_DEPTH runs of up to four bytes between front and back ends.
// Reset clears the held letter, the queue and the output valid.
module greek_to_latin_transliterator #(
    parameter int QUEUE_DEPTH = gtl_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);
    import gtl_pkg::*;

    gtl_queue_status_t q_status;
    gtl_run_t          push_run;
    gtl_run_t          head_run;
    logic              push;
    logic              pop;

    gtl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .in_byte  (in_byte),
        .q_status (q_status),
        .push     (push),
        .push_run (push_run)
    );

    gtl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head_run (head_run),
        .status   (q_status)
    );

    gtl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_run    (head_run),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// File: sv/gtl_checker.sv
// Port-level checker for the transliterator and its bind to the top level.
module gtl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       command,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run
);

    // A stalled result transfer keeps its byte and flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled result changed");

    // A clock edge seen in reset leaves the result channel idle.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid during reset");

    // A newline only ever closes a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte == 8'h0A) |-> last_of_run)
    else $error("newline not at end of run");

    // Bytes ahead of the last one in a run come from the table or a held letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !out_byte[7])
    else $error("non-ASCII byte inside a run");

endmodule

bind greek_to_latin_transliterator gtl_checker u_gtl_checker (.*);
